// File: rtl/core/aoi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aoi_pkg
// Types, constants and helper functions shared by the odometry integrator.
// ----------------------------------------------------------------------------
package aoi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_INV_STEER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_WHEELBASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_HEADING = 3'd4;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] INV_PI_Q63 = 64'h28BE60DB9391054A;
    localparam logic [63:0] PI2_FULL =
        (PI_Q60 + (64'd1 << (59 - 2*FRAC_BITS))) >> (60 - 2*FRAC_BITS);

    // divider remainder width: holds pi scaled by 2^(2F) shifted once, or a 31-bit cosine
    localparam int DEN_W = (2*FRAC_BITS + 3 > 33) ? 2*FRAC_BITS + 3 : 33;
    localparam logic [DEN_W-1:0] PI2 = PI2_FULL[DEN_W-1:0];

    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
    localparam logic [31:0] HALF_TURN = 32'h80000000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;
    localparam logic signed [47:0] S48_MAX = 48'sh7FFFFFFFFFFF;
    localparam logic signed [47:0] S48_MIN = 48'sh800000000000;

    typedef struct packed {
        logic signed [31:0] right_speed;
        logic signed [31:0] left_speed;
        logic signed [31:0] steer_reading;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic [31:0]        heading;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] yaw_rate;
    } out_item_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [31:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [95:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic             start;
        logic [DEN_W-1:0] rem0;
        logic [63:0]      num;
        logic [DEN_W-1:0] den;
        logic [6:0]       steps;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [63:0]      quo;
        logic [DEN_W-1:0] rem;
    } div_rsp_t;

    typedef struct packed {
        logic        start;
        logic [31:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic               done;
        logic signed [33:0] cos_v;
        logic signed [33:0] sin_v;
    } cordic_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STEER_MUL,
        S_STEER_MOD,
        S_STEER_ANG,
        S_TAN_ROT,
        S_TAN_DIV,
        S_OMEGA_MUL,
        S_OMEGA_SCALE,
        S_HEAD_ROT,
        S_VX_MUL,
        S_VY_MUL,
        S_TURN_MUL,
        S_FINISH
    } state_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0: r = 32'h20000000;
            5'd1: r = 32'h12E4051E;
            5'd2: r = 32'h09FB385B;
            5'd3: r = 32'h051111D4;
            5'd4: r = 32'h028B0D43;
            5'd5: r = 32'h0145D7E1;
            5'd6: r = 32'h00A2F61E;
            5'd7: r = 32'h00517C55;
            5'd8: r = 32'h0028BE53;
            5'd9: r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic [33:0] abs34(input logic signed [33:0] v);
        return v[33] ? 34'(-v) : 34'(v);
    endfunction

    // floor(signed product / 2^30), clamped to 32 bits
    function automatic logic signed [31:0] scale_vel(input logic [95:0] prod,
                                                      input logic neg);
        logic signed [63:0] sp;
        logic signed [63:0] q;
        sp = neg ? -$signed(prod[63:0]) : $signed(prod[63:0]);
        q = sp >>> 30;
        if (q > 64'(S32_MAX))
            return S32_MAX;
        else if (q < 64'(S32_MIN))
            return S32_MIN;
        else
            return q[31:0];
    endfunction

    function automatic logic signed [47:0] sat_add48(input logic signed [47:0] p,
                                                      input logic signed [31:0] d);
        logic signed [48:0] s;
        s = {p[47], p} + {{17{d[31]}}, d};
        if (s[48] != s[47])
            return s[48] ? S48_MIN : S48_MAX;
        else
            return s[47:0];
    endfunction

endpackage

// File: rtl/core/ackermann_odometry_integrator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ackermann_odometry_integrator_unit
// Bicycle-model odometry: wheel speeds and steering in, pose and rates out.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. Each item runs these steps (the tangent
// division is skipped when the steering cosine is exactly zero): six passes of
// the bit-serial multiplier, two 64-step passes of the restoring divider and
// one 31-step pass, and two CORDIC rotations, plus the idle state that takes
// the beat and a finish state that publishes it; the serial multiplier and
// divider are shared by these passes. A stalled output holds the block in its
// last step. A new beat is taken once the previous one has moved into the
// output register. Writing a start register reloads that pose element at once;
// configuration is taken while idle.
module ackermann_odometry_integrator_unit
    import aoi_pkg::*;
#(
    parameter int CORDIC_STEPS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    state_t state_reg, state_next;
    logic   pend_reg, pend_next;

    logic [31:0]        isf_reg, iwb_reg;
    logic signed [47:0] x_pos_reg, x_pos_next;
    logic signed [47:0] y_pos_reg, y_pos_next;
    logic [31:0]        head_reg, head_next;

    logic signed [31:0] v_reg, v_next;
    logic signed [31:0] st_reg, st_next;
    logic [63:0]        work_reg, work_next;
    logic               neg_reg, neg_next;
    logic [31:0]        ang_reg, ang_next;
    logic signed [31:0] tn_reg, tn_next;
    logic signed [31:0] om_reg, om_next;
    logic signed [31:0] vx_reg, vx_next;
    logic signed [31:0] vy_reg, vy_next;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    mul_req_t    mul_req;
    mul_rsp_t    mul_rsp;
    div_req_t    div_req;
    div_rsp_t    div_rsp;
    cordic_req_t cor_req;
    cordic_rsp_t cor_rsp;

    logic               cfg_fire;
    logic [32:0]        speed_sum;
    logic [DEN_W-1:0]   r0;
    logic [63:0]        qm;
    logic               tneg;
    logic [95:0]        om_sh, turn_sh;
    logic [63:0]        mm;
    logic               over;
    logic [31:0]        turn;
    logic [33:0]        c_mag, s_mag;

    aoi_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    aoi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    aoi_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cor_req),
        .rsp   (cor_rsp)
    );

    assign cfg_ready = (state_reg == S_IDLE);
    assign cfg_fire = cfg_valid && cfg_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        pend_next = pend_reg;
        x_pos_next = x_pos_reg;
        y_pos_next = y_pos_reg;
        head_next = head_reg;
        v_next = v_reg;
        st_next = st_reg;
        work_next = work_reg;
        neg_next = neg_reg;
        ang_next = ang_reg;
        tn_next = tn_reg;
        om_next = om_reg;
        vx_next = vx_reg;
        vy_next = vy_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next = out_data_reg;
        mul_req = '0;
        div_req = '0;
        cor_req = '0;
        c_mag = abs34(cor_rsp.cos_v);
        s_mag = abs34(cor_rsp.sin_v);
        speed_sum = {in_data.right_speed[31], in_data.right_speed}
                  + {in_data.left_speed[31], in_data.left_speed};
        r0 = div_rsp.rem;
        qm = div_rsp.quo;
        tneg = cor_rsp.sin_v[33] != cor_rsp.cos_v[33];
        om_sh = mul_rsp.prod >> (2*FRAC_BITS);
        mm = om_sh[63:0];
        over = |(mul_rsp.prod >> (64 + 2*FRAC_BITS));
        turn_sh = mul_rsp.prod >> (32 + FRAC_BITS);
        turn = turn_sh[31:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    v_next = $signed(speed_sum[32:1]);
                    st_next = in_data.steer_reading;
                    pend_next = 1'b0;
                    state_next = S_STEER_MUL;
                end
            end
            S_STEER_MUL:
            begin
                mul_req.a = {32'd0, isf_reg};
                mul_req.b = abs32(st_reg);
                mul_req.start = !pend_reg;
                pend_next = 1'b1;
                if (pend_reg && mul_rsp.done)
                begin
                    work_next = mul_rsp.prod[63:0];
                    neg_next = st_reg[31];
                    pend_next = 1'b0;
                    state_next = S_STEER_MOD;
                end
            end
            S_STEER_MOD:
            begin
                div_req.num = work_reg;
                div_req.den = PI2;
                div_req.steps = 7'd64;
                div_req.start = !pend_reg;
                pend_next = 1'b1;
                if (pend_reg && div_rsp.done)
                begin
                    // floor modulo: wrap a negative remainder into range
                    if (neg_reg && (r0 != '0))
                        work_next = 64'(PI2 - r0);
                    else
                        work_next = 64'(r0);
                    pend_next = 1'b0;
                    state_next = S_STEER_ANG;
                end
            end
            S_STEER_ANG:
            begin
                div_req.rem0 = work_reg[DEN_W-1:0];
                div_req.den = PI2;
                div_req.steps = 7'd31;
                div_req.start = !pend_reg;
                pend_next = 1'b1;
                if (pend_reg && div_rsp.done)
                begin
                    ang_next = qm[31:0];
                    pend_next = 1'b0;
                    state_next = S_TAN_ROT;
                end
            end
            S_TAN_ROT:
            begin
                cor_req.angle = ang_reg;
                cor_req.start = !pend_reg;
                pend_next = 1'b1;
                if (pend_reg && cor_rsp.done)
                begin
                    pend_next = 1'b0;
                    if (cor_rsp.cos_v == '0)
                    begin
                        tn_next = cor_rsp.sin_v[33] ? S32_MIN : S32_MAX;
                        state_next = S_OMEGA_MUL;
                    end
                    else
                        state_next = S_TAN_DIV;
                end
            end
            S_TAN_DIV:
            begin
                div_req.num = {30'd0, s_mag} << FRAC_BITS;
                div_req.den = DEN_W'(c_mag);
                div_req.steps = 7'd64;
                div_req.start = !pend_reg;
                pend_next = 1'b1;
                if (pend_reg && div_rsp.done)
                begin
                    if (tneg)
                        tn_next = (qm > 64'h80000000) ? S32_MIN : $signed(32'(-qm));
                    else
                        tn_next = (qm > 64'h7FFFFFFF) ? S32_MAX : $signed(qm[31:0]);
                    pend_next = 1'b0;
                    state_next = S_OMEGA_MUL;
                end
            end
            S_OMEGA_MUL:
            begin
                mul_req.a = {32'd0, abs32(tn_reg)};
                mul_req.b = abs32(v_reg);
                mul_req.start = !pend_reg;
                pend_next = 1'b1;
                if (pend_reg && mul_rsp.done)
                begin
                    work_next = mul_rsp.prod[63:0];
                    neg_next = v_reg[31] != tn_reg[31];
                    pend_next = 1'b0;
                    state_next = S_OMEGA_SCALE;
                end
            end
            S_OMEGA_SCALE:
            begin
                mul_req.a = work_reg;
                mul_req.b = iwb_reg;
                mul_req.start = !pend_reg;
                pend_next = 1'b1;
                if (pend_reg && mul_rsp.done)
                begin
                    if (neg_reg)
                        om_next = (over || mm > 64'h80000000) ? S32_MIN
                                                               : $signed(32'(-mm));
                    else
                        om_next = (over || mm > 64'h7FFFFFFF) ? S32_MAX
                                                               : $signed(mm[31:0]);
                    pend_next = 1'b0;
                    state_next = S_HEAD_ROT;
                end
            end
            S_HEAD_ROT:
            begin
                cor_req.angle = head_reg;
                cor_req.start = !pend_reg;
                pend_next = 1'b1;
                if (pend_reg && cor_rsp.done)
                begin
                    pend_next = 1'b0;
                    state_next = S_VX_MUL;
                end
            end
            S_VX_MUL:
            begin
                mul_req.a = {30'd0, c_mag};
                mul_req.b = abs32(v_reg);
                mul_req.start = !pend_reg;
                pend_next = 1'b1;
                if (pend_reg && mul_rsp.done)
                begin
                    vx_next = scale_vel(mul_rsp.prod, v_reg[31] != cor_rsp.cos_v[33]);
                    pend_next = 1'b0;
                    state_next = S_VY_MUL;
                end
            end
            S_VY_MUL:
            begin
                mul_req.a = {30'd0, s_mag};
                mul_req.b = abs32(v_reg);
                mul_req.start = !pend_reg;
                pend_next = 1'b1;
                if (pend_reg && mul_rsp.done)
                begin
                    vy_next = scale_vel(mul_rsp.prod, v_reg[31] != cor_rsp.sin_v[33]);
                    pend_next = 1'b0;
                    state_next = S_TURN_MUL;
                end
            end
            S_TURN_MUL:
            begin
                mul_req.a = INV_PI_Q63;
                mul_req.b = abs32(om_reg);
                mul_req.start = !pend_reg;
                pend_next = 1'b1;
                if (pend_reg && mul_rsp.done)
                begin
                    ang_next = om_reg[31] ? 32'd0 - turn : turn;
                    pend_next = 1'b0;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    x_pos_next = sat_add48(x_pos_reg, vx_reg);
                    y_pos_next = sat_add48(y_pos_reg, vy_reg);
                    head_next = head_reg + ang_reg;
                    out_data_next.pos_x = sat_add48(x_pos_reg, vx_reg);
                    out_data_next.pos_y = sat_add48(y_pos_reg, vy_reg);
                    out_data_next.heading = head_reg + ang_reg;
                    out_data_next.vel_x = vx_reg;
                    out_data_next.vel_y = vy_reg;
                    out_data_next.yaw_rate = om_reg;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_fire)
        begin
            case (cfg_index)
                REG_START_X: x_pos_next = $signed(cfg_data);
                REG_START_Y: y_pos_next = $signed(cfg_data);
                REG_START_HEADING: head_next = cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            isf_reg <= 32'h00010000;
            iwb_reg <= 32'h00010000;
            x_pos_reg <= '0;
            y_pos_reg <= '0;
            head_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg <= pend_next;
            out_valid_reg <= out_valid_next;
            x_pos_reg <= x_pos_next;
            y_pos_reg <= y_pos_next;
            head_reg <= head_next;
            if (cfg_fire && cfg_index == REG_INV_STEER)
                isf_reg <= cfg_data[31:0];
            if (cfg_fire && cfg_index == REG_INV_WHEELBASE)
                iwb_reg <= cfg_data[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        st_reg <= st_next;
        work_reg <= work_next;
        neg_reg <= neg_next;
        ang_reg <= ang_next;
        tn_reg <= tn_next;
        om_reg <= om_next;
        vx_reg <= vx_next;
        vy_reg <= vy_next;
        out_data_reg <= out_data_next;
    end

endmodule

// File: rtl/core/aoi_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aoi_mul
// Bit-serial unsigned multiplier, 64 by 32 bits, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module aoi_mul
    import aoi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic [96:0] acc_reg, acc_next;
    logic [63:0] a_reg, a_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] sum;

    always_comb
    begin
        acc_next = acc_reg;
        a_next = a_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sum = acc_reg[96:32] + (acc_reg[0] ? {1'b0, a_reg} : 65'd0);
        if (req.start)
        begin
            a_next = req.a;
            acc_next = {65'd0, req.b};
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // add on the low bit, then shift the multiplier out
            acc_next = {1'b0, sum, acc_reg[31:1]};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg <= a_next;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg[95:0];

endmodule

// File: rtl/core/aoi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aoi_div
// Restoring divider, one quotient bit a cycle, with a preset remainder.
// ----------------------------------------------------------------------------
module aoi_div
    import aoi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [63:0]      num_reg, num_next;
    logic [63:0]      quo_reg, quo_next;
    logic [6:0]       cnt_reg, cnt_next;
    logic [6:0]       steps_reg, steps_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W-1:0] sh;

    always_comb
    begin
        rem_next = rem_reg;
        den_next = den_reg;
        num_next = num_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        steps_next = steps_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sh = {rem_reg[DEN_W-2:0], num_reg[63]};
        if (req.start)
        begin
            rem_next = req.rem0;
            den_next = req.den;
            num_next = req.num;
            quo_next = '0;
            cnt_next = '0;
            steps_next = req.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // bring down the next dividend bit and try the subtract
            if (sh >= den_reg)
            begin
                rem_next = sh - den_reg;
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = sh;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            num_next = {num_reg[62:0], 1'b0};
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == steps_reg - 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        steps_reg <= steps_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo = quo_reg;
    assign rsp.rem = rem_reg;

endmodule

// File: rtl/core/aoi_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aoi_cordic
// Iterative rotation-mode CORDIC, one micro-rotation a cycle, cos and sin in Q4.30.
// ----------------------------------------------------------------------------
module aoi_cordic
    import aoi_pkg::*;
#(
    parameter int STEPS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cordic_req_t req,
    output cordic_rsp_t rsp
);

    localparam int CNT_W = $clog2(STEPS);

    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic               flip_reg, flip_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [4:0]         idx;
    logic signed [33:0] dx, dy, at, xs, ys;
    logic [31:0]        ang;
    logic               fl;

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        flip_next = flip_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        idx = 5'(cnt_reg);
        dx = y_reg >>> idx;
        dy = x_reg >>> idx;
        at = $signed({2'b00, atan_entry(idx)});
        fl = (req.angle[31:30] == 2'd1) || (req.angle[31:30] == 2'd2);
        ang = fl ? req.angle + HALF_TURN : req.angle;
        if (!z_reg[33])
        begin
            xs = x_reg - dx;
            ys = y_reg + dy;
            z_next = z_reg - at;
        end
        else
        begin
            xs = x_reg + dx;
            ys = y_reg - dy;
            z_next = z_reg + at;
        end
        if (req.start)
        begin
            // fold the middle quadrants onto the outer ones
            x_next = CORDIC_X0;
            y_next = '0;
            z_next = {{2{ang[31]}}, ang};
            flip_next = fl;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next = xs;
            y_next = ys;
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (flip_reg)
                begin
                    x_next = -xs;
                    y_next = -ys;
                end
            end
        end
        else
        begin
            z_next = z_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        flip_reg <= flip_next;
    end

    assign rsp.done = done_reg;
    assign rsp.cos_v = x_reg;
    assign rsp.sin_v = y_reg;

endmodule
